FILE: rtl/owm_pkg.sv
// owm_pkg: types, codes and constants shared by the 1-Wire master with ROM search.
// No dependencies.
package owm_pkg;

   localparam int ROM_BYTES_DEF   = 8;
   localparam int TIMER_WIDTH_DEF = 10;
   localparam int REG_WIDTH       = 10;
   localparam int REG_COUNT       = 8;
   localparam int REG_IDX_WIDTH   = 3;
   localparam int RESET_RECOVERY  = 410;
   localparam logic [7:0] SEARCH_COMMAND = 8'hF0;

   localparam logic [2:0] REG_SHORT_LOW = 3'd0;
   localparam logic [2:0] REG_ONE_REC   = 3'd1;
   localparam logic [2:0] REG_LONG_LOW  = 3'd2;
   localparam logic [2:0] REG_ZERO_REC  = 3'd3;
   localparam logic [2:0] REG_RD_WAIT   = 3'd4;
   localparam logic [2:0] REG_RD_REC    = 3'd5;
   localparam logic [2:0] REG_RST_LOW   = 3'd6;
   localparam logic [2:0] REG_PRES_WAIT = 3'd7;

   typedef enum logic [2:0] {
      REQ_TICK   = 3'd0,
      REQ_RESET  = 3'd1,
      REQ_WBIT   = 3'd2,
      REQ_RBIT   = 3'd3,
      REQ_WBYTE  = 3'd4,
      REQ_RBYTE  = 3'd5,
      REQ_SEARCH = 3'd6,
      REQ_NOP    = 3'd7
   } req_type_type;

   typedef enum logic [3:0] {
      PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC, PH_WR_LOW, PH_WR_REC,
      PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
   } phase_type;

   typedef enum logic [2:0] {
      ST_RST, ST_CMD, ST_RA, ST_RB, ST_WR
   } stage_type;

   localparam logic [2:0] STAT_OK     = 3'd0;
   localparam logic [2:0] STAT_NOPRES = 3'd1;
   localparam logic [2:0] STAT_MORE   = 3'd2;
   localparam logic [2:0] STAT_LAST   = 3'd3;
   localparam logic [2:0] STAT_BUSY   = 3'd4;

   // decoded word handed from the front to the engine
   typedef struct packed {
      req_type_type req;
      logic [7:0]   tx_data;
      logic         line_level;
   } cmd_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_data;
      logic [63:0] rom_code;
      logic [2:0] status;
   } res_type;

endpackage

FILE: rtl/owm_front.sv
// owm_front: input skid register and command classification.
// Depends on owm_pkg.
module owm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [15:0]       req_tdata,
   input  logic [2:0]        req_tuser,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output owm_pkg::cmd_type  cmd
);
   import owm_pkg::*;

   logic    full_ff, full_in;
   cmd_type buf_ff, buf_in;
   cmd_type dec;

   always_comb begin
      dec.req        = req_type_type'(req_tuser);
      dec.tx_data    = req_tdata[7:0];
      dec.line_level = req_tdata[8];
   end

   // one-word queue: accepts when empty or when drained in the same cycle
   assign req_tready = !full_ff || cmd_ready;
   assign cmd_valid  = full_ff;
   assign cmd        = buf_ff;

   always_comb begin
      full_in = full_ff;
      buf_in  = buf_ff;
      if (cmd_ready && full_ff) full_in = 1'b0;
      if (req_tvalid && req_tready) begin
         full_in = 1'b1;
         buf_in  = dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) full_ff <= 1'b0;
      else full_ff <= full_in;
      buf_ff <= buf_in;
   end
endmodule

FILE: rtl/owm_engine.sv
// owm_engine: bus timing engine, byte shifter and ROM search, one word per cycle
// when res_ready does not stall it, with an output register. Depends on owm_pkg.
module owm_engine #(
   parameter int ROM_BYTES   = owm_pkg::ROM_BYTES_DEF,
   parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  owm_pkg::cmd_type                cmd,
   input  logic                            csr_we,
   input  logic [owm_pkg::REG_IDX_WIDTH-1:0] csr_index,
   input  logic [owm_pkg::REG_WIDTH-1:0]   csr_wdata,
   output logic                            res_valid,
   input  logic                            res_ready,
   output owm_pkg::res_type                res
);
   import owm_pkg::*;

   localparam int ROM_BITS = ROM_BYTES * 8;
   localparam logic [TIMER_WIDTH-1:0] TMAX = {TIMER_WIDTH{1'b1}};

   logic [REG_WIDTH-1:0] regs_ff [REG_COUNT];

   phase_type             phase_ff, phase_in;
   req_type_type          op_ff, op_in;
   stage_type             stage_ff, stage_in;
   logic [TIMER_WIDTH-1:0] tl_ff, tl_in;
   logic [6:0]            bc_ff, bc_in;
   logic [7:0]            sb_ff, sb_in;
   logic [1:0]            rp_ff, rp_in;
   logic [63:0]           code_ff, code_in;
   logic [6:0]            ld_ff, ld_in;
   logic [6:0]            dm_ff, dm_in;
   logic                  sd_ff, sd_in;
   logic                  ov_ff, ov_in;
   res_type               out_ff, out_in;

   logic go;
   assign cmd_ready = !ov_ff || res_ready;
   assign go        = cmd_valid && cmd_ready;
   assign res_valid = ov_ff;
   assign res       = out_ff;

   function automatic logic [TIMER_WIDTH-1:0] dur(input logic [REG_WIDTH:0] v);
      logic [REG_WIDTH:0] m;
      m = (v == '0) ? (REG_WIDTH+1)'(1) : v;
      if (32'(m) > 32'(TMAX)) return TMAX;
      return TIMER_WIDTH'(m);
   endfunction

   always_comb begin
      logic fin, drv;
      logic [7:0] frx;
      logic [2:0] fst;
      logic [5:0] pos;
      logic dir;
      logic [6:0] idx;
      phase_in = phase_ff; op_in = op_ff; stage_in = stage_ff; tl_in = tl_ff;
      bc_in = bc_ff; sb_in = sb_ff; rp_in = rp_ff; code_in = code_ff;
      ld_in = ld_ff; dm_in = dm_ff; sd_in = sd_ff;
      fin = 1'b0; frx = '0; fst = STAT_OK; dir = 1'b0;
      idx = bc_ff; pos = 6'(bc_ff - 7'd1);
      drv = (phase_ff == PH_RST_LOW) || (phase_ff == PH_WR_LOW) ||
            (phase_ff == PH_RD_LOW);
      ov_in = ov_ff && !res_ready;
      out_in = out_ff;
      if (go) begin
         unique case (cmd.req)
            REQ_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  if (sd_ff) begin
                     sd_in = 1'b0;
                     if (phase_ff == PH_RST_REC) rp_in = {1'b0, cmd.line_level};
                     else if (op_ff == REQ_RBIT) sb_in = {7'd0, cmd.line_level};
                     else if (op_ff == REQ_RBYTE) sb_in = {cmd.line_level, sb_ff[7:1]};
                     else if (op_ff == REQ_SEARCH) begin
                        if (stage_ff == ST_RB) rp_in[1] = rp_ff[1] | cmd.line_level;
                        else rp_in[0] = rp_ff[0] | cmd.line_level;
                     end
                  end
                  if (tl_ff > '0) tl_in = tl_ff - 1'b1;
                  if (tl_in == '0) begin
                     unique case (phase_ff)
                        PH_RST_LOW: begin
                           phase_in = PH_RST_WAIT;
                           tl_in = dur({1'b0, regs_ff[REG_PRES_WAIT]});
                        end
                        PH_RST_WAIT: begin
                           phase_in = PH_RST_REC; sd_in = 1'b1;
                           tl_in = dur((REG_WIDTH+1)'(RESET_RECOVERY));
                        end
                        PH_WR_LOW: begin
                           phase_in = PH_WR_REC;
                           tl_in = dur({1'b0, sb_ff[0] ? regs_ff[REG_ONE_REC]
                                                      : regs_ff[REG_ZERO_REC]});
                        end
                        PH_RD_LOW: begin
                           if (regs_ff[REG_RD_WAIT] != '0) begin
                              phase_in = PH_RD_WAIT;
                              tl_in = dur({1'b0, regs_ff[REG_RD_WAIT]});
                           end else begin
                              phase_in = PH_RD_REC; sd_in = 1'b1;
                              tl_in = dur({1'b0, regs_ff[REG_RD_REC]});
                           end
                        end
                        PH_RD_WAIT: begin
                           phase_in = PH_RD_REC; sd_in = 1'b1;
                           tl_in = dur({1'b0, regs_ff[REG_RD_REC]});
                        end
                        default: begin
                           // slot end: sequence the operation
                           unique case (op_ff)
                              REQ_RESET: begin
                                 fin = 1'b1;
                                 fst = (rp_in == 2'd0) ? STAT_OK : STAT_NOPRES;
                              end
                              REQ_RBIT: begin fin = 1'b1; frx = {7'd0, sb_in[0]}; end
                              REQ_WBYTE: begin
                                 bc_in = bc_ff + 7'd1; sb_in = {1'b0, sb_ff[7:1]};
                                 if (bc_in >= 7'd8) fin = 1'b1;
                                 else begin
                                    phase_in = PH_WR_LOW;
                                    tl_in = dur({1'b0, sb_in[0] ? regs_ff[REG_SHORT_LOW]
                                                               : regs_ff[REG_LONG_LOW]});
                                 end
                              end
                              REQ_RBYTE: begin
                                 bc_in = bc_ff + 7'd1;
                                 if (bc_in >= 7'd8) begin fin = 1'b1; frx = sb_in; end
                                 else begin
                                    phase_in = PH_RD_LOW;
                                    tl_in = dur({1'b0, regs_ff[REG_SHORT_LOW]});
                                 end
                              end
                              REQ_SEARCH: begin
                                 unique case (stage_ff)
                                    ST_RST: begin
                                       if (rp_in != 2'd0) begin
                                          ld_in = '0; fin = 1'b1; fst = STAT_NOPRES;
                                       end else begin
                                          stage_in = ST_CMD; sb_in = SEARCH_COMMAND;
                                          bc_in = '0; dm_in = '0;
                                          phase_in = PH_WR_LOW;
                                          tl_in = dur({1'b0, regs_ff[REG_LONG_LOW]});
                                       end
                                    end
                                    ST_CMD: begin
                                       bc_in = bc_ff + 7'd1; sb_in = {1'b0, sb_ff[7:1]};
                                       if (bc_in >= 7'd8) begin
                                          stage_in = ST_RA; bc_in = 7'd1; rp_in = '0;
                                          phase_in = PH_RD_LOW;
                                          tl_in = dur({1'b0, regs_ff[REG_SHORT_LOW]});
                                       end else begin
                                          phase_in = PH_WR_LOW;
                                          tl_in = dur({1'b0, sb_in[0] ? regs_ff[REG_SHORT_LOW]
                                                                     : regs_ff[REG_LONG_LOW]});
                                       end
                                    end
                                    ST_RA: begin
                                       stage_in = ST_RB; phase_in = PH_RD_LOW;
                                       tl_in = dur({1'b0, regs_ff[REG_SHORT_LOW]});
                                    end
                                    ST_RB: begin
                                       if (rp_in == 2'd3) begin
                                          ld_in = '0; fin = 1'b1; fst = STAT_LAST;
                                       end else begin
                                          if (rp_in == 2'd0) begin
                                             if (idx == ld_ff) dir = 1'b1;
                                             else if (idx > ld_ff) begin
                                                dir = 1'b0; dm_in = idx;
                                             end else begin
                                                dir = code_ff[pos];
                                                if (!dir) dm_in = idx;
                                             end
                                          end else dir = rp_in[0];
                                          code_in[pos] = dir;
                                          sb_in = {7'd0, dir}; stage_in = ST_WR;
                                          phase_in = PH_WR_LOW;
                                          tl_in = dur({1'b0, dir ? regs_ff[REG_SHORT_LOW]
                                                                 : regs_ff[REG_LONG_LOW]});
                                       end
                                    end
                                    default: begin
                                       bc_in = bc_ff + 7'd1;
                                       if (bc_in > 7'(ROM_BITS)) begin
                                          ld_in = dm_ff; fin = 1'b1;
                                          fst = (dm_ff != '0) ? STAT_MORE : STAT_LAST;
                                       end else begin
                                          stage_in = ST_RA; rp_in = '0;
                                          phase_in = PH_RD_LOW;
                                          tl_in = dur({1'b0, regs_ff[REG_SHORT_LOW]});
                                       end
                                    end
                                 endcase
                              end
                              default: fin = 1'b1;
                           endcase
                        end
                     endcase
                  end
               end
            end
            REQ_NOP: ;
            default: begin
               if (phase_ff != PH_IDLE) fst = STAT_BUSY;
               else begin
                  op_in = cmd.req; bc_in = '0; sd_in = 1'b0;
                  unique case (cmd.req)
                     REQ_RESET, REQ_SEARCH: begin
                        stage_in = ST_RST;
                        if (!cmd.line_level) begin
                           if (cmd.req == REQ_SEARCH) ld_in = '0;
                           fin = 1'b1; fst = STAT_NOPRES;
                        end else begin
                           rp_in = 2'd1; phase_in = PH_RST_LOW;
                           tl_in = dur({1'b0, regs_ff[REG_RST_LOW]});
                        end
                     end
                     REQ_WBIT, REQ_WBYTE: begin
                        sb_in = (cmd.req == REQ_WBIT) ? {7'd0, cmd.tx_data[0]} : cmd.tx_data;
                        phase_in = PH_WR_LOW;
                        tl_in = dur({1'b0, sb_in[0] ? regs_ff[REG_SHORT_LOW]
                                                   : regs_ff[REG_LONG_LOW]});
                     end
                     default: begin
                        sb_in = '0; phase_in = PH_RD_LOW;
                        tl_in = dur({1'b0, regs_ff[REG_SHORT_LOW]});
                     end
                  endcase
                  drv = (phase_in == PH_RST_LOW) || (phase_in == PH_WR_LOW) ||
                        (phase_in == PH_RD_LOW);
               end
            end
         endcase
         if (fin) begin
            phase_in = PH_IDLE; op_in = REQ_TICK; tl_in = '0;
         end
         ov_in = 1'b1;
         out_in.drive_low = drv;
         out_in.busy_res  = (phase_in != PH_IDLE);
         out_in.done_res  = fin;
         out_in.rx_data   = fin ? frx : 8'd0;
         out_in.rom_code  = code_in;
         out_in.status    = fst;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; op_ff <= REQ_TICK; stage_ff <= ST_RST; tl_ff <= '0;
         bc_ff <= '0; sb_ff <= '0; rp_ff <= '0; code_ff <= '0; ld_ff <= '0;
         dm_ff <= '0; sd_ff <= 1'b0; ov_ff <= 1'b0;
         regs_ff[REG_SHORT_LOW] <= 10'd6;   regs_ff[REG_ONE_REC]   <= 10'd64;
         regs_ff[REG_LONG_LOW]  <= 10'd60;  regs_ff[REG_ZERO_REC]  <= 10'd10;
         regs_ff[REG_RD_WAIT]   <= 10'd9;   regs_ff[REG_RD_REC]    <= 10'd55;
         regs_ff[REG_RST_LOW]   <= 10'd480; regs_ff[REG_PRES_WAIT] <= 10'd70;
      end else begin
         phase_ff <= phase_in; op_ff <= op_in; stage_ff <= stage_in; tl_ff <= tl_in;
         bc_ff <= bc_in; sb_ff <= sb_in; rp_ff <= rp_in; code_ff <= code_in;
         ld_ff <= ld_in; dm_ff <= dm_in; sd_ff <= sd_in; ov_ff <= ov_in;
         if (csr_we) regs_ff[csr_index] <= csr_wdata;
      end
      out_ff <= out_in;
   end
endmodule

FILE: rtl/one_wire_master_with_rom_search_core.sv
// one_wire_master_with_rom_search_core: top level of the 1-Wire master.
// Depends on owm_pkg, owm_front, owm_engine.
//
//  channel | dir | fields (LSB up)
//  req     | in  | tuser: req_type[2:0]; tdata: tx_data[7:0] line_level[8]
//  rsp     | out | tdata: drive_low busy_res done_res rx_data[7:0] rom_code[63:0] status[2:0]
//  csr     | in  | csr_we, csr_index[2:0], csr_wdata[9:0], no read-back
//
// Flow: one word per clock while rsp_tready is high; a word passes through the input
// queue and then the engine output register. Every word, tick or command, is
// resolved by the engine's combinational logic; the bit timer counts ticks, not clocks.
// Reset: synchronous, clears queue, engine state and ROM code, reloads the
// timing registers with their defaults.
// Stalls: rsp_tready low holds the result register; the one-word queue
// absorbs one more word before req_tready drops.
module one_wire_master_with_rom_search_core #(
   parameter int ROM_BYTES   = owm_pkg::ROM_BYTES_DEF,
   parameter int TIMER_WIDTH = owm_pkg::TIMER_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,  // tx_data, line_level
   input  logic [2:0]                        req_tuser,  // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [79:0]                       rsp_tdata,  // drive_low, busy_res, done_res,
                                                          // rx_data, rom_code, status
   input  logic                              csr_we,
   input  logic [owm_pkg::REG_IDX_WIDTH-1:0] csr_index,
   input  logic [owm_pkg::REG_WIDTH-1:0]     csr_wdata
);
   import owm_pkg::*;

   cmd_type cmd;
   logic    cmd_valid, cmd_ready;
   res_type res;

   owm_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .cmd_valid, .cmd_ready, .cmd
   );

   owm_engine #(.ROM_BYTES(ROM_BYTES), .TIMER_WIDTH(TIMER_WIDTH)) u_engine (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .csr_we, .csr_index, .csr_wdata,
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res
   );

   assign rsp_tdata = {2'b00, res.status, res.rom_code, res.rx_data,
                       res.done_res, res.busy_res, res.drive_low};
endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for the 1-Wire master with ROM search.
// Depends on owm_pkg and one_wire_master_with_rom_search_core; predicts every result word.
module testbench;
   import owm_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int RANDOM_STOP = 500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // tx_data[7:0], line_level[8]
   logic [2:0]  req_tuser = '0;   // req_type[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // drive_low[0], busy_res[1], done_res[2], rx_data[10:3],
                                  // rom_code[74:11], status[77:75]
   logic        csr_we = 1'b0;
   logic [REG_IDX_WIDTH-1:0] csr_index = '0;
   logic [REG_WIDTH-1:0]     csr_wdata = '0;

   one_wire_master_with_rom_search_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Bus master predictor: own copy of timing registers and state.
   // ---------------------------------------------------------------
   int unsigned  slot_reg [8];
   phase_type    bus_phase;
   req_type_type bus_op;
   stage_type    srch_stage;
   int unsigned  ticks_left, bit_idx, shreg, pair_bits, last_disc, disc_mark;
   logic [63:0]  rom_acc;
   bit           sample_pending;
   bit           op_done;
   int unsigned  done_rx, done_status;

   res_type      rom_results_due [$];
   int           mismatches = 0;
   int           words_sent = 0;
   int           cycle_count = 0;
   bit           gaps_on = 1'b1;
   int unsigned  pair_target = 0;
   int unsigned  eleven_pct = 0;

   function automatic int unsigned clamp_us(int unsigned v);
      if (v == 0) return 1;
      if (v > 1023) return 1023;
      return v;
   endfunction

   function automatic void go_phase(phase_type p, int unsigned t);
      bus_phase = p;
      ticks_left = clamp_us(t);
   endfunction

   function automatic void begin_write_slot();
      go_phase(PH_WR_LOW, shreg[0] ? slot_reg[REG_SHORT_LOW] : slot_reg[REG_LONG_LOW]);
   endfunction

   function automatic void begin_read_slot();
      go_phase(PH_RD_LOW, slot_reg[REG_SHORT_LOW]);
   endfunction

   function automatic void close_op(int unsigned rx, int unsigned st);
      bus_phase = PH_IDLE;
      bus_op = REQ_TICK;
      ticks_left = 0;
      op_done = 1'b1;
      done_rx = rx & 8'hFF;
      done_status = st;
   endfunction

   function automatic void latch_sample(int unsigned v);
      if (bus_phase == PH_RST_REC) begin
         pair_bits = v;
         return;
      end
      case (bus_op)
         REQ_RBIT:   shreg = v;
         REQ_RBYTE:  shreg = ((shreg >> 1) | (v << 7)) & 8'hFF;
         REQ_SEARCH: pair_bits |= v << (srch_stage == ST_RB ? 1 : 0);
         default: ;
      endcase
   endfunction

   // choose the ROM bit direction from the two response bits
   function automatic void pick_rom_bit();
      int unsigned pos, dir;
      pos = (bit_idx - 1) & 63;
      if (pair_bits == 3) begin
         last_disc = 0;
         close_op(0, STAT_LAST);
         return;
      end
      if (pair_bits == 0) begin
         if (bit_idx == last_disc) dir = 1;
         else if (bit_idx > last_disc) begin
            dir = 0;
            disc_mark = bit_idx;
         end else begin
            dir = rom_acc[pos];
            if (dir == 0) disc_mark = bit_idx;
         end
      end else dir = pair_bits & 1;
      rom_acc[pos] = dir[0];
      shreg = dir;
      srch_stage = ST_WR;
      begin_write_slot();
   endfunction

   function automatic void end_of_slot();
      case (bus_op)
         REQ_RESET: close_op(0, pair_bits == 0 ? STAT_OK : STAT_NOPRES);
         REQ_WBIT:  close_op(0, STAT_OK);
         REQ_RBIT:  close_op(shreg & 1, STAT_OK);
         REQ_WBYTE: begin
            bit_idx++;
            shreg >>= 1;
            if (bit_idx >= 8) close_op(0, STAT_OK); else begin_write_slot();
         end
         REQ_RBYTE: begin
            bit_idx++;
            if (bit_idx >= 8) close_op(shreg, STAT_OK); else begin_read_slot();
         end
         REQ_SEARCH: begin
            case (srch_stage)
               ST_RST: begin
                  if (pair_bits != 0) begin
                     last_disc = 0;
                     close_op(0, STAT_NOPRES);
                  end else begin
                     srch_stage = ST_CMD;
                     shreg = SEARCH_COMMAND;
                     bit_idx = 0;
                     disc_mark = 0;
                     begin_write_slot();
                  end
               end
               ST_CMD: begin
                  bit_idx++;
                  shreg >>= 1;
                  if (bit_idx >= 8) begin
                     srch_stage = ST_RA;
                     bit_idx = 1;
                     pair_bits = 0;
                     begin_read_slot();
                  end else begin_write_slot();
               end
               ST_RA: begin
                  srch_stage = ST_RB;
                  begin_read_slot();
               end
               ST_RB: pick_rom_bit();
               default: begin
                  bit_idx++;
                  if (bit_idx > ROM_BYTES_DEF * 8) begin
                     last_disc = disc_mark;
                     close_op(0, disc_mark != 0 ? STAT_MORE : STAT_LAST);
                  end else begin
                     srch_stage = ST_RA;
                     pair_bits = 0;
                     begin_read_slot();
                  end
               end
            endcase
         end
         default: close_op(0, STAT_OK);
      endcase
   endfunction

   function automatic void advance_us(int unsigned line);
      if (sample_pending) begin
         sample_pending = 1'b0;
         latch_sample(line);
      end
      if (ticks_left > 0) ticks_left--;
      if (ticks_left != 0) return;
      case (bus_phase)
         PH_RST_LOW:  go_phase(PH_RST_WAIT, slot_reg[REG_PRES_WAIT]);
         PH_RST_WAIT: begin
            go_phase(PH_RST_REC, RESET_RECOVERY);
            sample_pending = 1'b1;
         end
         PH_WR_LOW: go_phase(PH_WR_REC, shreg[0] ? slot_reg[REG_ONE_REC] : slot_reg[REG_ZERO_REC]);
         PH_RD_LOW: begin
            if (slot_reg[REG_RD_WAIT] != 0) go_phase(PH_RD_WAIT, slot_reg[REG_RD_WAIT]);
            else begin
               go_phase(PH_RD_REC, slot_reg[REG_RD_REC]);
               sample_pending = 1'b1;
            end
         end
         PH_RD_WAIT: begin
            go_phase(PH_RD_REC, slot_reg[REG_RD_REC]);
            sample_pending = 1'b1;
         end
         default: end_of_slot();
      endcase
   endfunction

   function automatic bit pulling_low();
      return bus_phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW};
   endfunction

   function automatic res_type predict_word(req_type_type req, logic [7:0] tx, logic line);
      res_type r;
      bit drv;
      op_done = 1'b0;
      done_rx = 0;
      done_status = STAT_OK;
      if (req == REQ_TICK) begin
         drv = pulling_low();
         if (bus_phase != PH_IDLE) advance_us(line);
      end else if (req == REQ_NOP) begin
         drv = pulling_low();
      end else if (bus_phase != PH_IDLE) begin
         drv = pulling_low();
         done_status = STAT_BUSY;
      end else begin
         bus_op = req;
         bit_idx = 0;
         sample_pending = 1'b0;
         case (req)
            REQ_RESET, REQ_SEARCH: begin
               srch_stage = ST_RST;
               if (line == 1'b0) begin
                  if (req == REQ_SEARCH) last_disc = 0;
                  close_op(0, STAT_NOPRES);
               end else begin
                  pair_bits = 1;
                  go_phase(PH_RST_LOW, slot_reg[REG_RST_LOW]);
               end
            end
            REQ_WBIT: begin
               shreg = tx[0];
               begin_write_slot();
            end
            REQ_WBYTE: begin
               shreg = tx;
               begin_write_slot();
            end
            default: begin
               shreg = 0;
               begin_read_slot();
            end
         endcase
         drv = pulling_low();
      end
      r.drive_low = drv;
      r.busy_res  = (bus_phase != PH_IDLE);
      r.done_res  = op_done;
      r.rx_data   = op_done ? done_rx[7:0] : 8'h00;
      r.rom_code  = rom_acc;
      r.status    = done_status[2:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   function automatic int unsigned draw_gap();
      return gaps_on ? $urandom_range(0, 3) : 0;
   endfunction

   // line level for the next tick; steers presence and search responses
   function automatic logic pick_line();
      if (!sample_pending) return 1'($urandom_range(0, 1));
      if (bus_phase == PH_RST_REC) return ($urandom_range(0, 9) != 0) ? 1'b0 : 1'b1;
      if (bus_op == REQ_SEARCH) begin
         if (srch_stage == ST_RA) begin
            pair_target = ($urandom_range(0, 99) < eleven_pct) ? 3 : $urandom_range(0, 2);
            return pair_target[0];
         end
         return pair_target[1];
      end
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_word(req_type_type req, logic [7:0] tx, logic line);
      int unsigned gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, line, tx};
      req_tuser  <= req;
      do @(posedge clock); while (!req_tready);
      rom_results_due.push_back(predict_word(req, tx, line));
      words_sent++;
   endtask

   task automatic send_tick();
      send_word(REQ_TICK, 8'($urandom_range(0, 255)), pick_line());
   endtask

   // pause the sender until every outstanding result word is back
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (rom_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, int unsigned val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[REG_WIDTH-1:0];
      slot_reg[idx] = val & 10'h3FF;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_timing(int unsigned v [8]);
      drain();
      for (int i = 0; i < REG_COUNT; i++) write_reg(i[2:0], v[i]);
   endtask

   // issue one command and tick it to completion; optional noise words in between
   task automatic run_op(req_type_type req, logic [7:0] tx, logic start_line, bit noisy);
      int unsigned r;
      send_word(req, tx, start_line);
      while (bus_phase != PH_IDLE) begin
         r = $urandom_range(0, 99);
         if (noisy && r < 3) send_word(req_type_type'(3'($urandom_range(1, 6))),
                                       8'($urandom_range(0, 255)),
                                       1'($urandom_range(0, 1)));
         else if (noisy && r < 5) send_word(REQ_NOP, 8'($urandom_range(0, 255)),
                                            1'($urandom_range(0, 1)));
         else send_tick();
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_directed_basics();
      int unsigned quick [8] = '{2, 2, 3, 2, 1, 2, 4, 2};
      // reset values first: idle tick, no-op code, line shorted on reset and search
      send_word(REQ_TICK, 8'hFF, 1'b1);
      send_word(REQ_NOP, 8'h00, 1'b0);
      run_op(REQ_RESET, 8'h00, 1'b0, 1'b0);
      run_op(REQ_SEARCH, 8'hFF, 1'b0, 1'b0);
      run_op(REQ_WBIT, 8'h01, 1'b1, 1'b0);
      load_timing(quick);
      run_op(REQ_WBIT, 8'hFE, 1'b1, 1'b0);
      run_op(REQ_WBYTE, 8'hFF, 1'b1, 1'b0);
      run_op(REQ_WBYTE, 8'h00, 1'b0, 1'b0);
      run_op(REQ_RBIT, 8'h00, 1'b1, 1'b0);
      run_op(REQ_RBYTE, 8'h5A, 1'b1, 1'b0);
      // busy rejection in the middle of a slot
      send_word(REQ_WBYTE, 8'h3C, 1'b1);
      send_word(REQ_RBIT, 8'hFF, 1'b1);
      send_word(REQ_NOP, 8'hFF, 1'b1);
      while (bus_phase != PH_IDLE) send_tick();
   endtask

   // shortest timings keep the 64-bit search passes and the reset cheap
   task automatic test_timing_extremes();
      int unsigned mins [8] = '{1, 1, 1, 1, 0, 1, 1, 1};
      int unsigned zeros [8] = '{0, 0, 0, 0, 0, 0, 0, 0};
      load_timing(mins);
      run_op(REQ_RBYTE, 8'h00, 1'b1, 1'b0);
      run_op(REQ_WBYTE, 8'hC3, 1'b1, 1'b0);
      eleven_pct = 0;
      run_op(REQ_SEARCH, 8'h00, 1'b1, 1'b0);
      // second pass resumes from the last discrepancy, usually cut short by 11
      eleven_pct = 20;
      run_op(REQ_SEARCH, 8'h00, 1'b1, 1'b0);
      eleven_pct = 0;
      load_timing(zeros);   // zero counts as one microsecond; zero read wait: phase skipped
      run_op(REQ_RBIT, 8'h00, 1'b1, 1'b0);
      run_op(REQ_WBIT, 8'h01, 1'b1, 1'b0);
      run_op(REQ_RESET, 8'h00, 1'b1, 1'b0);
   endtask

   task automatic test_random_traffic();
      int unsigned cfg [8];
      int unsigned ops_in_cfg;
      req_type_type req;
      ops_in_cfg = 0;
      while (words_sent < RANDOM_STOP) begin
         if (ops_in_cfg == 0) begin
            for (int i = 0; i < REG_COUNT; i++) cfg[i] = $urandom_range(0, 5);
            load_timing(cfg);
            gaps_on = ($urandom_range(0, 3) != 0);
            ops_in_cfg = $urandom_range(5, 20);
         end
         ops_in_cfg--;
         req = req_type_type'(3'($urandom_range(2, 5)));
         run_op(req, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
         if ($urandom_range(0, 9) == 0) send_word(REQ_TICK, 8'($urandom_range(0, 255)),
                                                  1'($urandom_range(0, 1)));
      end
      gaps_on = 1'b1;
   endtask

   // ---------------------------------------------------------------
   // Result side: random stalls, then compare against oldest prediction
   // ---------------------------------------------------------------
   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0d] %s: got %h want %h", cycle_count, what, got, want);
      mismatches++;
   endtask

   initial begin
      int unsigned stall;
      @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rom_results_due.size() == 0) begin
            report_mismatch("result word with nothing pending", rsp_tdata[63:0], '0);
         end else begin
            want = rom_results_due.pop_front();
            if (rsp_tdata[0] !== want.drive_low)
               report_mismatch("drive_low", rsp_tdata[0], want.drive_low);
            if (rsp_tdata[1] !== want.busy_res)
               report_mismatch("busy_res", rsp_tdata[1], want.busy_res);
            if (rsp_tdata[2] !== want.done_res)
               report_mismatch("done_res", rsp_tdata[2], want.done_res);
            if (rsp_tdata[10:3] !== want.rx_data)
               report_mismatch("rx_data", rsp_tdata[10:3], want.rx_data);
            if (rsp_tdata[74:11] !== want.rom_code)
               report_mismatch("rom_code", rsp_tdata[74:11], want.rom_code);
            if (rsp_tdata[77:75] !== want.status)
               report_mismatch("status", rsp_tdata[77:75], want.status);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      slot_reg = '{6, 64, 60, 10, 9, 55, 480, 70};
      bus_phase = PH_IDLE;
      bus_op = REQ_TICK;
      srch_stage = ST_RST;
      ticks_left = 0; bit_idx = 0; shreg = 0; pair_bits = 0;
      last_disc = 0; disc_mark = 0; rom_acc = '0; sample_pending = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_basics();
      test_random_traffic();
      test_timing_extremes();

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && rom_results_due.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/owm_pkg.sv
rtl/owm_front.sv
rtl/owm_engine.sv
rtl/one_wire_master_with_rom_search_core.sv
verif/testbench.sv
